/* src/ssdb_pkg.sv */
package ssdb_pkg;

    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned COUNT_W    = 4;

    localparam logic [15:0] BEEP_LENGTH_RESET = 16'd200;

    localparam logic [7:0] CHAR_B  = 8'h42;
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_REFRESH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        SCAN_UNITS    = 2'd0,
        SCAN_TENS     = 2'd1,
        SCAN_HUNDREDS = 2'd2,
        SCAN_OFF      = 2'd3
    } t_scan;

    // Three BCD digits, hundreds in the top nibble.
    typedef logic [11:0] t_bcd3;

    // Output beat layout, highest bit first.
    typedef struct packed {
        logic [3:0]  pad;
        logic        buzzer_running;
        logic        buzzer_level;
        logic [6:0]  segments;
        logic [2:0]  digit_select;
        logic [15:0] shown_score;
    } t_out_beat;

    // Common-cathode pattern, bit 0 is segment a.
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pat;
        unique case (digit)
            4'd0:    pat = 7'b0111111;
            4'd1:    pat = 7'b0000110;
            4'd2:    pat = 7'b1011011;
            4'd3:    pat = 7'b1001111;
            4'd4:    pat = 7'b1100110;
            4'd5:    pat = 7'b1101101;
            4'd6:    pat = 7'b1111101;
            4'd7:    pat = 7'b0000111;
            4'd8:    pat = 7'b1111111;
            4'd9:    pat = 7'b1101111;
            default: pat = 7'b0000000;
        endcase
        return pat;
    endfunction

    // k * 65536 modulo 1000 in BCD, for the overflow count k of accum*10+d.
    function automatic t_bcd3 wrap_bcd(input logic [3:0] k);
        t_bcd3 v;
        unique case (k)
            4'd0:    v = 12'h000;
            4'd1:    v = 12'h536;
            4'd2:    v = 12'h072;
            4'd3:    v = 12'h608;
            4'd4:    v = 12'h144;
            4'd5:    v = 12'h680;
            4'd6:    v = 12'h216;
            4'd7:    v = 12'h752;
            4'd8:    v = 12'h288;
            4'd9:    v = 12'h824;
            default: v = 12'h000;
        endcase
        return v;
    endfunction

    // (a - c) modulo 1000, digit by digit with borrow.
    function automatic t_bcd3 bcd_sub(input t_bcd3 a, input t_bcd3 c);
        t_bcd3      r;
        logic       borrow;
        logic [4:0] t;
        r      = '0;
        borrow = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t = {1'b0, a[4*i +: 4]} - {1'b0, c[4*i +: 4]} - {4'd0, borrow};
            if (t[4]) begin
                t      = t + 5'd10;
                borrow = 1'b1;
            end else begin
                borrow = 1'b0;
            end
            r[4*i +: 4] = t[3:0];
        end
        return r;
    endfunction

endpackage

/* src/serial_score_display_buzzer.sv */
// Serial score display with buzzer.
// Input channel (i_s_*): one beat per event. tuser carries the event kind
// (0 received byte, 1 buzzer tick, 2 display refresh step; 3 changes nothing),
// tdata carries the received byte. Every input beat yields exactly one
// output beat on o_m_* with the score shown, the lit digit and its segments,
// and the buzzer pin level and running flag, all as left by that event.
// Configuration channel (i_cfg_*): writes beep_length; always ready. The user
// must write it only while no beat is in flight; the block does not enforce it.
// Each beat passes through one input register; all decoding, the digit
// accumulation (kept in binary and as its low three decimal digits) and
// the buzzer counter update then feed the output register directly.
// Throughput is one beat per cycle while i_m_tready is high; the input
// register refills in the same cycle that it hands its beat to the
// output register. When the receiver holds i_m_tready low, the output
// beat holds, the input register holds one more beat, and then
// o_s_tready drops.
// Reset clears the score, accumulator, buzzer and scan state (units digit
// lit) and sets beep_length to 200.
module serial_score_display_buzzer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic [1:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // shown_score[15:0], digit_select[18:16], segments[25:19],
    // buzzer_level[26], buzzer_running[27], zero[31:28]
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import ssdb_pkg::*;

    logic                r_in_valid;
    logic [1:0]          r_in_mode;
    logic [7:0]          r_in_byte;

    logic [15:0]         r_beep_length;
    logic [15:0]         r_score;
    t_bcd3               r_score_bcd;
    logic [15:0]         r_accum;
    t_bcd3               r_accum_bcd;
    logic [COUNT_W-1:0]  r_count;
    logic                r_beep_active;
    logic [15:0]         r_beep_count;
    logic                r_pin;
    logic [1:0]          r_scan;

    logic [15:0]         n_score;
    t_bcd3               n_score_bcd;
    logic [15:0]         n_accum;
    t_bcd3               n_accum_bcd;
    logic [COUNT_W-1:0]  n_count;
    logic                n_beep_active;
    logic [15:0]         n_beep_count;
    logic                n_pin;
    logic [1:0]          n_scan;

    logic                r_out_valid;
    t_out_beat           r_out;
    t_out_beat           n_out;

    logic                advance;
    logic [19:0]         wide;
    logic [3:0]          digit;
    logic [15:0]         tick_count;

    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;
    assign o_cfg_ready = 1'b1;

    assign digit      = r_in_byte[3:0];
    assign wide       = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0} + {16'd0, digit};
    assign tick_count = r_beep_count + 16'd1;

    always_comb begin
        n_score       = r_score;
        n_score_bcd   = r_score_bcd;
        n_accum       = r_accum;
        n_accum_bcd   = r_accum_bcd;
        n_count       = r_count;
        n_beep_active = r_beep_active;
        n_beep_count  = r_beep_count;
        n_pin         = r_pin;
        n_scan        = r_scan;

        unique case (r_in_mode)
            MODE_BYTE: begin
                priority if (r_in_byte == CHAR_B) begin
                    n_beep_active = 1'b1;
                    n_beep_count  = '0;
                end else if (r_in_byte == CHAR_S) begin
                    n_accum     = '0;
                    n_accum_bcd = '0;
                    n_count     = '0;
                end else if (r_in_byte >= CHAR_0 && r_in_byte <= CHAR_9) begin
                    if (r_count < COUNT_W'(MAX_DIGITS)) begin
                        n_accum = wide[15:0];
                        // Low three decimal digits after the 16-bit wrap.
                        n_accum_bcd = bcd_sub({r_accum_bcd[7:0], digit},
                                              wrap_bcd(wide[19:16]));
                        n_count = r_count + COUNT_W'(1);
                    end
                end else if (r_in_byte == CHAR_LF && r_count != '0) begin
                    n_score     = r_accum;
                    n_score_bcd = r_accum_bcd;
                    n_accum     = '0;
                    n_accum_bcd = '0;
                    n_count     = '0;
                end
            end
            MODE_TICK: begin
                if (r_beep_active) begin
                    if (tick_count >= r_beep_length) begin
                        n_beep_active = 1'b0;
                        n_beep_count  = '0;
                        n_pin         = 1'b0;
                    end else begin
                        n_beep_count = tick_count;
                        n_pin        = !r_pin;
                    end
                end
            end
            MODE_REFRESH: begin
                n_scan = (r_scan == SCAN_UNITS) ? SCAN_TENS :
                         (r_scan == SCAN_TENS)  ? SCAN_HUNDREDS : SCAN_UNITS;
            end
            default: begin
            end
        endcase

        n_out                = '0;
        n_out.shown_score    = n_score;
        n_out.buzzer_level   = n_pin;
        n_out.buzzer_running = n_beep_active;
        unique case (n_scan)
            SCAN_UNITS: begin
                n_out.digit_select = 3'b001;
                n_out.segments     = seg_pattern(n_score_bcd[3:0]);
            end
            SCAN_TENS: begin
                if (n_score >= 16'd10) begin
                    n_out.digit_select = 3'b010;
                    n_out.segments     = seg_pattern(n_score_bcd[7:4]);
                end
            end
            SCAN_HUNDREDS: begin
                if (n_score >= 16'd100) begin
                    n_out.digit_select = 3'b100;
                    n_out.segments     = seg_pattern(n_score_bcd[11:8]);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_beep_length <= BEEP_LENGTH_RESET;
            r_score       <= '0;
            r_score_bcd   <= '0;
            r_accum       <= '0;
            r_accum_bcd   <= '0;
            r_count       <= '0;
            r_beep_active <= 1'b0;
            r_beep_count  <= '0;
            r_pin         <= 1'b0;
            r_scan        <= SCAN_UNITS;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_beep_length <= i_cfg_data;
            end
            if (advance) begin
                r_score       <= n_score;
                r_score_bcd   <= n_score_bcd;
                r_accum       <= n_accum;
                r_accum_bcd   <= n_accum_bcd;
                r_count       <= n_count;
                r_beep_active <= n_beep_active;
                r_beep_count  <= n_beep_count;
                r_pin         <= n_pin;
                r_scan        <= n_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode <= i_s_tuser;
            r_in_byte <= i_s_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
